[hdl/spq_pkg.sv]
// Shared types, codes and default sizes of the sorted priority queue.
package spq_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int KEY_BITS_DEF     = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} spq_func_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_REMOVE_EMPTY = 2'd1,
		ST_INSERT_FULL  = 2'd2
	} spq_status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} spq_cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; #(
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	parameter int CNT_BITS     = 5,
	parameter int IDX          = 0
) (
	input  logic                    clk,
	input  spq_cell_ctrl_t          ctrl,
	input  logic [CNT_BITS-1:0]     count,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    left_mark,
	input  logic [KEY_BITS-1:0]     left_key,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic [KEY_BITS-1:0]     right_key,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                    mark,
	output logic [KEY_BITS-1:0]     key,
	output logic [PAYLOAD_BITS-1:0] payload,
	output logic [KEY_BITS-1:0]     nxt_key,
	output logic [PAYLOAD_BITS-1:0] nxt_payload
);

	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    occupied;

	// A slot is marked when the new entry belongs here or further toward the front.
	assign occupied = CNT_BITS'(IDX) < count;
	assign mark     = !occupied || (new_key < key_q);

	always_comb begin
		nxt_key     = key_q;
		nxt_payload = payload_q;
		if (ctrl.ins) begin
			if (mark) begin
				if (left_mark) begin
					nxt_key     = left_key;
					nxt_payload = left_payload;
				end else begin
					nxt_key     = new_key;
					nxt_payload = new_payload;
				end
			end
		end else if (ctrl.rem) begin
			nxt_key     = right_key;
			nxt_payload = right_payload;
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= nxt_key;
		payload_q <= nxt_payload;
	end

	assign key     = key_q;
	assign payload = payload_q;

endmodule

[hdl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
// Input channel s_*: one transfer is one command. s_tuser carries func (insert or
// remove-min), s_tdata carries the key and payload of an entry to insert.
// Output channel m_*: every accepted command yields exactly one result transfer with
// the front entry after the command, the entry count, an empty flag and a status
// (ok, remove on empty, insert on full with the entry dropped).
// The result is registered: it is valid in the cycle after the command transfer.
// Throughput is one command per cycle while the receiver takes results; the whole chain
// of cells shifts together, every cell comparing its key with the new key and taking
// its neighbor's entry, the new entry or keeping its own.
// The result register decouples the two sides: a new command is taken while the
// previous result is being taken in the same cycle. When the receiver stalls, the
// result holds and s_tready drops until it is taken.
// Reset empties the queue (count zero) and drops any pending result; the entry
// slots themselves are not cleared and are only read below the count.
module sorted_priority_queue_unit import spq_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	parameter int CNT_BITS     = $clog2(DEPTH + 1),
	parameter int IN_W         = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
	parameter int OUT_W        = ((KEY_BITS + PAYLOAD_BITS + CNT_BITS + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// s_tdata fields, lowest bit up: key, payload
	input  logic [IN_W-1:0]  s_tdata,
	// s_tuser fields, lowest bit up: func
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// m_tdata fields, lowest bit up: min_key, min_payload, entry_count, is_empty, status
	output logic [OUT_W-1:0] m_tdata
);

	logic                    accept;
	logic                    is_remove;
	logic                    full;
	logic [KEY_BITS-1:0]     new_key;
	logic [PAYLOAD_BITS-1:0] new_payload;
	logic [CNT_BITS-1:0]     count_q;
	logic [CNT_BITS-1:0]     count_nxt;
	spq_cell_ctrl_t          ctrl;
	spq_status_t             status_nxt;

	logic                    mark_w        [DEPTH];
	logic [KEY_BITS-1:0]     key_w         [DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_w     [DEPTH];
	logic [KEY_BITS-1:0]     nxt_key_w     [DEPTH];
	logic [PAYLOAD_BITS-1:0] nxt_payload_w [DEPTH];

	logic                    out_valid_q;
	logic [KEY_BITS-1:0]     min_key_q;
	logic [PAYLOAD_BITS-1:0] min_payload_q;
	logic [CNT_BITS-1:0]     entry_count_q;
	logic                    is_empty_q;
	spq_status_t             status_q;

	// Take a command whenever the result register is free or being emptied.
	assign s_tready    = !out_valid_q || m_tready;
	assign accept      = s_tvalid && s_tready;
	assign is_remove   = (s_tuser == FUNC_REMOVE);
	assign full        = (count_q == CNT_BITS'(DEPTH));
	assign new_key     = s_tdata[KEY_BITS-1:0];
	assign new_payload = s_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];

	// Decide the command for the chain; errors leave the chain untouched.
	always_comb begin
		ctrl       = '0;
		status_nxt = ST_OK;
		count_nxt  = count_q;
		if (accept) begin
			if (!is_remove) begin
				if (full) begin
					status_nxt = ST_INSERT_FULL;
				end else begin
					ctrl.ins  = 1'b1;
					count_nxt = count_q + CNT_BITS'(1);
				end
			end else begin
				if (count_q == '0) begin
					status_nxt = ST_REMOVE_EMPTY;
				end else begin
					ctrl.rem  = 1'b1;
					count_nxt = count_q - CNT_BITS'(1);
				end
			end
		end
	end

	// The chain: each cell sees its left neighbor for inserts and its right for removes.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    left_mark;
		logic [KEY_BITS-1:0]     left_key;
		logic [PAYLOAD_BITS-1:0] left_payload;
		logic [KEY_BITS-1:0]     right_key;
		logic [PAYLOAD_BITS-1:0] right_payload;

		if (i == 0) begin : g_head
			assign left_mark    = 1'b0;
			assign left_key     = new_key;
			assign left_payload = new_payload;
		end else begin : g_body
			assign left_mark    = mark_w[i-1];
			assign left_key     = key_w[i-1];
			assign left_payload = payload_w[i-1];
		end

		// The tail refills with its own entry, which lies beyond the count anyway.
		if (i == DEPTH - 1) begin : g_tail
			assign right_key     = key_w[i];
			assign right_payload = payload_w[i];
		end else begin : g_inner
			assign right_key     = key_w[i+1];
			assign right_payload = payload_w[i+1];
		end

		spq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.CNT_BITS     (CNT_BITS),
			.IDX          (i)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.count         (count_q),
			.new_key       (new_key),
			.new_payload   (new_payload),
			.left_mark     (left_mark),
			.left_key      (left_key),
			.left_payload  (left_payload),
			.right_key     (right_key),
			.right_payload (right_payload),
			.mark          (mark_w[i]),
			.key           (key_w[i]),
			.payload       (payload_w[i]),
			.nxt_key       (nxt_key_w[i]),
			.nxt_payload   (nxt_payload_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the front entry as it will stand after this command; zero when empty.
	always_ff @(posedge clk) begin
		if (accept) begin
			min_key_q     <= (count_nxt == '0) ? '0 : nxt_key_w[0];
			min_payload_q <= (count_nxt == '0) ? '0 : nxt_payload_w[0];
			entry_count_q <= count_nxt;
			is_empty_q    <= (count_nxt == '0);
			status_q      <= status_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({status_q, is_empty_q, entry_count_q, min_payload_q, min_key_q});

	// The count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("entry count above depth");

	// An insert into a full queue reports the drop and leaves the count alone.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_remove && full |=> status_q == ST_INSERT_FULL
			&& count_q == CNT_BITS'(DEPTH))
		else $error("insert on full not reported");

	// The two front cells stay in key order.
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_BITS'(2) |-> key_w[0] <= key_w[1])
		else $error("front entries out of order");

	// A pending result agrees with itself on emptiness.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> is_empty_q == (entry_count_q == '0))
		else $error("empty flag disagrees with count");

endmodule
